>>> rtl/core/hpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared types and constants of the homography point warp.
// ----------------------------------------------------------------------------
package hpw_pkg;

  // Number of quotient bits the divider resolves, one per stage.
  localparam int unsigned DivSteps = 32;
  // Number of multiply and sum stages in front of the divider.
  localparam int unsigned MacStages = 3;
  // One in signed Q16.32, as wide as a coefficient with its unit term.
  localparam logic signed [48:0] OneQ32 = 49'sh0_0001_0000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgGainXxDelta = 3'd0,
    CfgGainYx      = 3'd1,
    CfgPerspX      = 3'd2,
    CfgGainXy      = 3'd3,
    CfgGainYyDelta = 3'd4,
    CfgPerspY      = 3'd5,
    CfgShiftX      = 3'd6,
    CfgShiftY      = 3'd7
  } cfg_idx_e;

  // Word handed to one divider lane.
  typedef struct packed {
    logic [80:0] dvd;  // |N| * 2^16 + floor(d / 2)
    logic [63:0] den;  // positive denominator
    logic        neg;  // numerator was negative
  } div_in_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [63:0] rem;  // partial remainder, below den unless ovf is set
    logic [31:0] lq;   // dividend bits still to come, quotient bits shifted in
    logic [63:0] den;
    logic        neg;
    logic        ovf;  // quotient is 2^32 or more
  } div_stage_t;

endpackage

>>> rtl/core/homography_point_warp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_point_warp
// Maps integer pixel points through a projective warp into Q16.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write the eight Q16.32 coefficients through cfg_valid_i,
//   cfg_index_i and cfg_data_i while no point is in flight; cfg_ready_o is
//   always high. Reset loads zeros, which is the identity warp.
//   Input: a point word (x_in_i, y_in_i) is taken at every edge with start
//   high; busy stays low, so one point enters each cycle.
//   Output: done_o marks each result word for exactly one cycle. Each point
//   passes the split multipliers and sums, the sign and rounding setup, the
//   divider (one quotient bit per stage) and then the output register.
//   Throughput is one point per cycle. The receiver cannot stall; results
//   leave in input order. valid_res_o is low, with zero coordinates, when
//   the denominator is not positive. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module homography_point_warp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] x_in_i,
  input  logic signed [15:0] y_in_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic               valid_res_o
);

  localparam int unsigned VldDepth = hpw_pkg::MacStages + 1 + hpw_pkg::DivSteps;
  localparam int unsigned OkDepth  = hpw_pkg::DivSteps + 1;

  logic [47:0]        coef_q [8];
  logic signed [48:0] axx, ayx, px, axy, ayy, py, tx, ty;
  logic signed [66:0] den_s, nx_s, ny_s;
  logic [66:0]        mag_x, mag_y;
  logic               den_ok;
  hpw_pkg::div_in_t   dx_d, dy_d, dx_q, dy_q;
  logic [31:0]        res_x, res_y;
  logic [VldDepth-1:0] vld_q;
  logic [OkDepth-1:0]  ok_q;
  logic               done_q, vres_q;
  logic [31:0]        xo_q, yo_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (hpw_pkg::cfg_idx_e'(cfg_index_i))
        hpw_pkg::CfgGainXxDelta: coef_q[hpw_pkg::CfgGainXxDelta] <= cfg_data_i;
        hpw_pkg::CfgGainYx:      coef_q[hpw_pkg::CfgGainYx]      <= cfg_data_i;
        hpw_pkg::CfgPerspX:      coef_q[hpw_pkg::CfgPerspX]      <= cfg_data_i;
        hpw_pkg::CfgGainXy:      coef_q[hpw_pkg::CfgGainXy]      <= cfg_data_i;
        hpw_pkg::CfgGainYyDelta: coef_q[hpw_pkg::CfgGainYyDelta] <= cfg_data_i;
        hpw_pkg::CfgPerspY:      coef_q[hpw_pkg::CfgPerspY]      <= cfg_data_i;
        hpw_pkg::CfgShiftX:      coef_q[hpw_pkg::CfgShiftX]      <= cfg_data_i;
        hpw_pkg::CfgShiftY:      coef_q[hpw_pkg::CfgShiftY]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficients widened by one bit; the diagonal terms carry their unit.
  always_comb begin
    axx = $signed({coef_q[hpw_pkg::CfgGainXxDelta][47], coef_q[hpw_pkg::CfgGainXxDelta]})
        + hpw_pkg::OneQ32;
    ayy = $signed({coef_q[hpw_pkg::CfgGainYyDelta][47], coef_q[hpw_pkg::CfgGainYyDelta]})
        + hpw_pkg::OneQ32;
    ayx = $signed({coef_q[hpw_pkg::CfgGainYx][47], coef_q[hpw_pkg::CfgGainYx]});
    axy = $signed({coef_q[hpw_pkg::CfgGainXy][47], coef_q[hpw_pkg::CfgGainXy]});
    px  = $signed({coef_q[hpw_pkg::CfgPerspX][47], coef_q[hpw_pkg::CfgPerspX]});
    py  = $signed({coef_q[hpw_pkg::CfgPerspY][47], coef_q[hpw_pkg::CfgPerspY]});
    tx  = $signed({coef_q[hpw_pkg::CfgShiftX][47], coef_q[hpw_pkg::CfgShiftX]});
    ty  = $signed({coef_q[hpw_pkg::CfgShiftY][47], coef_q[hpw_pkg::CfgShiftY]});
  end

  // Denominator and both numerators, exact.
  hpw_mac u_mac_den (
    .clk_i    (clk_i),
    .coef_a_i (px),
    .coef_b_i (py),
    .offs_i   (hpw_pkg::OneQ32),
    .x_i      (x_in_i),
    .y_i      (y_in_i),
    .sum_o    (den_s)
  );

  hpw_mac u_mac_nx (
    .clk_i    (clk_i),
    .coef_a_i (axx),
    .coef_b_i (axy),
    .offs_i   (tx),
    .x_i      (x_in_i),
    .y_i      (y_in_i),
    .sum_o    (nx_s)
  );

  hpw_mac u_mac_ny (
    .clk_i    (clk_i),
    .coef_a_i (ayx),
    .coef_b_i (ayy),
    .offs_i   (ty),
    .x_i      (x_in_i),
    .y_i      (y_in_i),
    .sum_o    (ny_s)
  );

  // Rounding setup: magnitude scaled by 2^16 plus half the denominator.
  always_comb begin
    den_ok = !den_s[66] && (den_s != '0);
    mag_x  = nx_s[66] ? 67'd0 - nx_s : nx_s;
    mag_y  = ny_s[66] ? 67'd0 - ny_s : ny_s;
    dx_d.dvd = {1'b0, mag_x[63:0], 16'b0} + {18'b0, den_s[63:1]};
    dx_d.den = den_s[63:0];
    dx_d.neg = nx_s[66];
    dy_d.dvd = {1'b0, mag_y[63:0], 16'b0} + {18'b0, den_s[63:1]};
    dy_d.den = den_s[63:0];
    dy_d.neg = ny_s[66];
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  hpw_div u_div_x (
    .clk_i (clk_i),
    .in_i  (dx_q),
    .res_o (res_x)
  );

  hpw_div u_div_y (
    .clk_i (clk_i),
    .in_i  (dy_q),
    .res_o (res_y)
  );

  // Valid bits travel alongside the data; the sign check joins at setup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ok_q   <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[VldDepth-2:0], start};
      ok_q   <= {ok_q[OkDepth-2:0], den_ok};
      done_q <= vld_q[VldDepth-1];
    end
  end

  // Output register; invalid points read as zero.
  always_ff @(posedge clk_i) begin
    vres_q <= ok_q[OkDepth-1];
    xo_q   <= ok_q[OkDepth-1] ? res_x : 32'd0;
    yo_q   <= ok_q[OkDepth-1] ? res_y : 32'd0;
  end

  assign done_o      = done_q;
  assign x_out_o     = $signed(xo_q);
  assign y_out_o     = $signed(yo_q);
  assign valid_res_o = vres_q;

endmodule

>>> rtl/core/hpw_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_mac
// Three-stage lane computing a*x + b*y + k exactly, with split multipliers.
// ----------------------------------------------------------------------------
module hpw_mac (
  input  logic               clk_i,
  input  logic signed [48:0] coef_a_i,
  input  logic signed [48:0] coef_b_i,
  input  logic signed [48:0] offs_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  output logic signed [66:0] sum_o
);

  logic signed [40:0] pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;
  logic signed [48:0] offs1_q, offs2_q;
  logic signed [64:0] prod_a_q, prod_b_q, prod_a_d, prod_b_d;
  logic signed [66:0] sum_q, sum_d;

  // Stage one: each coefficient is split into a low unsigned and a high signed half.
  always_ff @(posedge clk_i) begin
    pa_lo_q <= 41'($signed({1'b0, coef_a_i[23:0]}) * x_i);
    pa_hi_q <= 41'($signed(coef_a_i[48:24]) * x_i);
    pb_lo_q <= 41'($signed({1'b0, coef_b_i[23:0]}) * y_i);
    pb_hi_q <= 41'($signed(coef_b_i[48:24]) * y_i);
    offs1_q <= offs_i;
  end

  // Stage two: recombine the partial products.
  always_comb begin
    prod_a_d = $signed({pa_hi_q, 24'b0}) + $signed({{24{pa_lo_q[40]}}, pa_lo_q});
    prod_b_d = $signed({pb_hi_q, 24'b0}) + $signed({{24{pb_lo_q[40]}}, pb_lo_q});
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    offs2_q  <= offs1_q;
  end

  // Stage three: sum of both products and the offset.
  always_comb begin
    sum_d = $signed({{2{prod_a_q[64]}}, prod_a_q}) + $signed({{2{prod_b_q[64]}}, prod_b_q})
          + $signed({{18{offs2_q[48]}}, offs2_q});
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

>>> rtl/core/hpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module hpw_div (
  input  logic            clk_i,
  input  hpw_pkg::div_in_t in_i,
  output logic [31:0]     res_o
);

  hpw_pkg::div_stage_t stg_in [hpw_pkg::DivSteps];
  hpw_pkg::div_stage_t stg_q  [hpw_pkg::DivSteps];
  hpw_pkg::div_stage_t stg_d  [hpw_pkg::DivSteps];
  logic [31:0]         quo;

  // The upper dividend bits seed the remainder; if they already reach the
  // divisor the quotient cannot fit in 32 bits.
  always_comb begin
    stg_in[0].rem = {15'b0, in_i.dvd[80:32]};
    stg_in[0].lq  = in_i.dvd[31:0];
    stg_in[0].den = in_i.den;
    stg_in[0].neg = in_i.neg;
    stg_in[0].ovf = {15'b0, in_i.dvd[80:32]} >= in_i.den;
  end

  for (genvar k = 0; k < hpw_pkg::DivSteps; k++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg_q[k-1];
    end

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
      trial = {stg_in[k].rem, stg_in[k].lq[31]};
      diff  = trial - {1'b0, stg_in[k].den};
      stg_d[k] = stg_in[k];
      if (trial >= {1'b0, stg_in[k].den}) begin
        stg_d[k].rem = diff[63:0];
        stg_d[k].lq  = {stg_in[k].lq[30:0], 1'b1};
      end else begin
        stg_d[k].rem = trial[63:0];
        stg_d[k].lq  = {stg_in[k].lq[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k] <= stg_d[k];
    end
  end

  // Apply the sign and clamp to the Q16.16 range.
  assign quo = stg_q[hpw_pkg::DivSteps-1].lq;

  always_comb begin
    if (stg_q[hpw_pkg::DivSteps-1].neg) begin
      if (stg_q[hpw_pkg::DivSteps-1].ovf || quo > 32'h8000_0000) begin
        res_o = 32'h8000_0000;
      end else begin
        res_o = 32'd0 - quo;
      end
    end else begin
      if (stg_q[hpw_pkg::DivSteps-1].ovf || quo[31]) begin
        res_o = 32'h7FFF_FFFF;
      end else begin
        res_o = quo;
      end
    end
  end

endmodule

>>> dv/homography_point_warp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_point_warp_tb
// Self-checking bench for the homography point warp. Coefficients are loaded
// through the write channel between phases while the pipeline is empty. Points
// are streamed with random sender gaps. Every result word is compared with a
// warp computed in the bench from the same coefficients.
// ----------------------------------------------------------------------------
module homography_point_warp_tb;

  // One point word on its way into the block.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  // One warped point as the block should return it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ok;
  } warped_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] x_in_i;
  logic signed [15:0] y_in_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [47:0]        cfg_data_i;
  logic               done_o;
  logic signed [31:0] x_out_o;
  logic signed [31:0] y_out_o;
  logic               valid_res_o;

  homography_point_warp uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .valid_res_o (valid_res_o)
  );

  point_t             pending_points[$];
  warped_t            expected_warps[$];
  logic signed [47:0] coef[8];
  int                 idle_pct;
  int                 error_count;
  logic               cfg_pending;
  logic [2:0]         cfg_idx_q;
  logic [47:0]        cfg_val_q;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Rounded, saturated Q16.16 quotient of a Q.32 numerator by a positive
  // Q.32 denominator, ties away from zero.
  function automatic logic signed [31:0] divide_q16(logic signed [127:0] num,
                                                    logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 16) + (den >> 1)) / den;
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  // Projects one point through the current coefficients.
  function automatic warped_t warp_point(point_t p);
    logic signed [127:0] px;
    logic signed [127:0] py;
    logic signed [127:0] one;
    logic signed [127:0] d;
    logic signed [127:0] nx;
    logic signed [127:0] ny;
    warped_t             w;
    px = p.x;
    py = p.y;
    one = 128'sh1_0000_0000;
    d = coef[hpw_pkg::CfgPerspX] * px + coef[hpw_pkg::CfgPerspY] * py + one;
    w = '{x: '0, y: '0, ok: 1'b0};
    if (d > 0) begin
      nx = (coef[hpw_pkg::CfgGainXxDelta] + one) * px + coef[hpw_pkg::CfgGainXy] * py
         + coef[hpw_pkg::CfgShiftX];
      ny = coef[hpw_pkg::CfgGainYx] * px + (coef[hpw_pkg::CfgGainYyDelta] + one) * py
         + coef[hpw_pkg::CfgShiftY];
      w.x = divide_q16(nx, d);
      w.y = divide_q16(ny, d);
      w.ok = 1'b1;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: takes words from the pending queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      x_in_i <= '0;
      y_in_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_warps.push_back(warp_point('{x: x_in_i, y: y_in_i}));
      end
      if (!(start && busy)) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start  <= 1'b1;
          x_in_i <= pending_points[0].x;
          y_in_i <= pending_points[0].y;
          void'(pending_points.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Configuration channel: one write held until ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_index_i <= hpw_pkg::CfgGainXxDelta;
      cfg_data_i  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      coef[cfg_index_i] = cfg_data_i;
      cfg_valid_i <= 1'b0;
      cfg_pending = 1'b0;
    end else if (cfg_pending && !cfg_valid_i) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_q;
      cfg_data_i  <= cfg_val_q;
    end
  end

  // Monitor: checks each result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_warps.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        warped_t w;
        w = expected_warps.pop_front();
        if (x_out_o !== w.x) report_mismatch("x_out", x_out_o, w.x);
        if (y_out_o !== w.y) report_mismatch("y_out", y_out_o, w.y);
        if (valid_res_o !== w.ok) report_mismatch("valid_res", valid_res_o, w.ok);
      end
    end
  end

  task automatic write_coef(hpw_pkg::cfg_idx_e idx, logic [47:0] val);
    cfg_idx_q = idx;
    cfg_val_q = val;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || start || expected_warps.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(15) - 8;
      1: return $urandom_range(511) - 256;
      default: return $urandom();
    endcase
  endfunction

  // Random coefficient near a typical size, sometimes at the extremes.
  function automatic logic [47:0] rand_coef(int kind);
    logic [47:0] v;
    v = {$urandom(), $urandom()};
    case (kind)
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return {{20{v[27]}}, v[27:0]};
      3: return {{30{v[17]}}, v[17:0]};
      default: return v;
    endcase
  endfunction

  function automatic point_t make_point(logic [15:0] x, logic [15:0] y);
    return '{x: x, y: y};
  endfunction

  // Stimulus: directed points under the identity and under extreme coefficients, then random phases.
  initial begin
    cfg_cfg_init();
  end

  task automatic cfg_cfg_init();
    int phase;
    int k;
    logic [15:0] edges[5];
    error_count = 0;
    idle_pct = 0;
    cfg_pending = 1'b0;
    foreach (coef[i]) coef[i] = '0;
    edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity warp on extreme and near-zero coordinates.
    foreach (edges[i]) foreach (edges[j]) begin
      pending_points.push_back(make_point(edges[i], edges[j]));
    end
    drain();

    // Extreme coefficients: saturation and a denominator at or below zero.
    for (int i = 0; i < 8; i++) write_coef(hpw_pkg::cfg_idx_e'(i), 48'h7FFF_FFFF_FFFF);
    pending_points.push_back(make_point(16'h7FFF, 16'h7FFF));
    pending_points.push_back(make_point(16'h8000, 16'h0000));
    pending_points.push_back(make_point(16'h0000, 16'h8000));
    drain();
    write_coef(hpw_pkg::CfgPerspX, 48'hFFFF_0000_0000);  // -1: d is zero at x = 1
    write_coef(hpw_pkg::CfgPerspY, 48'h0);
    pending_points.push_back(make_point(16'h0001, 16'h0003));
    pending_points.push_back(make_point(16'h0002, 16'h0000));
    drain();
    for (int i = 0; i < 8; i++) write_coef(hpw_pkg::cfg_idx_e'(i), 48'h8000_0000_0000);
    pending_points.push_back(make_point(16'h7FFF, 16'h8000));
    pending_points.push_back(make_point(16'hFFFF, 16'hFFFF));
    drain();

    // Random phases, each with fresh coefficients and an idle pattern.
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 12;
        default: idle_pct = $urandom_range(50);
      endcase
      for (int i = 0; i < 8; i++) begin
        k = (i == hpw_pkg::CfgPerspX || i == hpw_pkg::CfgPerspY) ? 3 : 2;
        if ($urandom_range(9) == 0) k = $urandom_range(4);
        if ((phase == 5) && i == hpw_pkg::CfgShiftX) k = 0;
        write_coef(hpw_pkg::cfg_idx_e'(i), rand_coef(k));
      end
      for (k = 0; k < 85; k++) begin
        pending_points.push_back(make_point(rand_coord(), rand_coord()));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("homography_point_warp: match");
    end else begin
      $display("homography_point_warp: mismatch");
    end
    $finish;
  endtask

  // Watchdog.
  initial begin
    #5ms;
    $display("homography_point_warp: mismatch");
    $finish;
  end

endmodule
